### hdl/generational_handle_allocator_top_macros.svh
// Assertion macros shared by the checker of the handle allocator.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define GHA_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GHA_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/gha_pkg.sv
// Shared constants and types of the generational handle allocator.
// Used by the controller, the datapath, the top level and the checker.
package gha_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int ID_W       = $clog2(SLOT_COUNT);
  localparam int USED_W     = ID_W + 1;
  localparam int VER_W      = 16;
  localparam int DATA_W     = 32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_STALE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // latch the request and read the tables
    logic exec;    // update the tables and load the result register
  } cmd_t;

endpackage

### hdl/gha_ctrl.sv
// Controller of the handle allocator: request sequencing and result handshake.
// Depends on gha_pkg.
module gha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output gha_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.accept = in_tvalid && (state_r == S_IDLE);
    // The result register must be free, or emptied in this cycle, before a new result lands.
    cmd.exec   = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/gha_dpath.sv
// Datapath of the handle allocator: slot tables, free-list head, fill count and result register.
// Depends on gha_pkg.
module gha_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gha_pkg::cmd_t             cmd,
  input  logic                      in_opcode,
  input  logic [gha_pkg::ID_W-1:0]  in_handle_id,
  input  logic [gha_pkg::VER_W-1:0] in_handle_version,
  output logic [1:0]                out_status,
  output logic [gha_pkg::ID_W-1:0]  out_id,
  output logic [gha_pkg::VER_W-1:0] out_version
);

  logic [gha_pkg::ID_W-1:0]  link_mem  [gha_pkg::SLOT_COUNT];
  logic [gha_pkg::VER_W-1:0] ver_mem   [gha_pkg::SLOT_COUNT];
  logic                      alive_mem [gha_pkg::SLOT_COUNT];

  logic                       op_r;
  logic [gha_pkg::ID_W-1:0]   id_r;
  logic [gha_pkg::VER_W-1:0]  ver_in_r;
  logic [gha_pkg::ID_W-1:0]   link_rd_r;
  logic [gha_pkg::VER_W-1:0]  ver_rd_r;
  logic                       alive_rd_r;

  logic [gha_pkg::ID_W-1:0]   head_r, head_nxt;
  logic                       head_vld_r, head_vld_nxt;
  logic [gha_pkg::USED_W-1:0] used_r, used_nxt;

  logic [1:0]                 status_r, status_nxt;
  logic [gha_pkg::ID_W-1:0]   oid_r, oid_nxt;
  logic [gha_pkg::VER_W-1:0]  over_r, over_nxt;

  logic [gha_pkg::ID_W-1:0]   rd_addr;
  logic                       is_alloc, fresh_ok, free_ok;
  logic                       link_we, ver_we, alive_we, alive_wd;
  logic [gha_pkg::ID_W-1:0]   ver_wa, alive_wa, link_wd;
  logic [gha_pkg::VER_W-1:0]  ver_wd;

  assign rd_addr  = (in_opcode == gha_pkg::OP_FREE) ? in_handle_id : head_r;
  assign is_alloc = (op_r == gha_pkg::OP_ALLOC);
  assign fresh_ok = (used_r != gha_pkg::USED_W'(gha_pkg::SLOT_COUNT));
  // Ids at or above the fill count were never handed out, so their table reads are ignored.
  assign free_ok  = ({1'b0, id_r} < used_r) && alive_rd_r && (ver_rd_r == ver_in_r);

  always_comb begin
    link_we  = cmd.exec && !is_alloc && free_ok;
    link_wd  = head_vld_r ? head_r : id_r;
    ver_we   = cmd.exec && (is_alloc ? (!head_vld_r && fresh_ok) : free_ok);
    ver_wa   = is_alloc ? used_r[gha_pkg::ID_W-1:0] : id_r;
    ver_wd   = is_alloc ? '0 : ver_rd_r + gha_pkg::VER_W'(1);
    alive_we = cmd.exec && (is_alloc ? (head_vld_r || fresh_ok) : free_ok);
    alive_wa = is_alloc ? (head_vld_r ? head_r : used_r[gha_pkg::ID_W-1:0]) : id_r;
    alive_wd = is_alloc;
  end

  always_comb begin
    head_nxt     = head_r;
    head_vld_nxt = head_vld_r;
    used_nxt     = used_r;
    status_nxt   = gha_pkg::ST_OK;
    oid_nxt      = '0;
    over_nxt     = '0;
    if (is_alloc) begin
      priority if (head_vld_r) begin
        // A link pointing back at its own slot ends the list.
        if (link_rd_r != head_r) head_nxt = link_rd_r;
        else                     head_vld_nxt = 1'b0;
        oid_nxt  = head_r;
        over_nxt = ver_rd_r;
      end else if (fresh_ok) begin
        used_nxt = used_r + gha_pkg::USED_W'(1);
        oid_nxt  = used_r[gha_pkg::ID_W-1:0];
      end else begin
        status_nxt = gha_pkg::ST_FULL;
      end
    end else begin
      if (free_ok) begin
        head_nxt     = id_r;
        head_vld_nxt = 1'b1;
      end else begin
        status_nxt = gha_pkg::ST_STALE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[id_r] <= link_wd;
    if (cmd.accept) link_rd_r <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ver_we) ver_mem[ver_wa] <= ver_wd;
    if (cmd.accept) ver_rd_r <= ver_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (alive_we) alive_mem[alive_wa] <= alive_wd;
    if (cmd.accept) alive_rd_r <= alive_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_opcode;
      id_r     <= in_handle_id;
      ver_in_r <= in_handle_version;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      oid_r    <= oid_nxt;
      over_r   <= over_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      head_vld_r <= 1'b0;
      used_r     <= '0;
    end else if (cmd.exec) begin
      head_r     <= head_nxt;
      head_vld_r <= head_vld_nxt;
      used_r     <= used_nxt;
    end
  end

  assign out_status  = status_r;
  assign out_id      = oid_r;
  assign out_version = over_r;

endmodule

### hdl/generational_handle_allocator_top.sv
// Channel | Direction | Content
// in_     | slave     | tuser: opcode; tdata: handle_id, handle_version
// out_    | master    | tuser: status; tdata: out_id, out_version
//
// A request is accepted in S_IDLE, whose edge reads the slot tables (one
// synchronous read port per table); an edge in S_EXEC writes them back and
// loads the result register once it is free or being emptied, so a stalled
// result holds the next request in S_EXEC. Reset empties the free list and
// the fill count; tables need no clearing pass, so requests are taken at once.
// Top level of the generational handle allocator; depends on gha_pkg, gha_ctrl and gha_dpath.
module generational_handle_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [9:0] handle_id, [25:10] handle_version, [31:26] zero
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [9:0] out_id, [25:10] out_version, [31:26] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  gha_pkg::cmd_t             cmd;
  logic [gha_pkg::ID_W-1:0]  res_id;
  logic [gha_pkg::VER_W-1:0] res_ver;

  gha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  gha_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_opcode         (in_tuser),
    .in_handle_id      (in_tdata[gha_pkg::ID_W-1:0]),
    .in_handle_version (in_tdata[gha_pkg::ID_W +: gha_pkg::VER_W]),
    .out_status        (out_tuser),
    .out_id            (res_id),
    .out_version       (res_ver)
  );

  assign out_tdata = {{(gha_pkg::DATA_W - gha_pkg::ID_W - gha_pkg::VER_W){1'b0}}, res_ver, res_id};

endmodule

### hdl/gha_checker.sv
// Port-level checker for the handle allocator, bound to the top level.
// Depends on gha_pkg and generational_handle_allocator_top_macros.svh.
`include "generational_handle_allocator_top_macros.svh"

module gha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `GHA_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=>
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `GHA_ASSERT_RUN(a_two_cycle, in_tvalid && in_tready |=> !in_tready,
    "request taken in back-to-back cycles")
  `GHA_ASSERT_RUN(a_status_code, out_tvalid |-> out_tuser != 2'd3, "undefined status code")
  `GHA_ASSERT_RUN(a_fail_zero, out_tvalid && out_tuser != gha_pkg::ST_OK |->
    out_tdata == 32'd0, "failed transaction carries a handle")
  `GHA_ASSERT_ALL(a_reset_idle, !rst_n |=> !out_tvalid && in_tready,
    "block not idle after reset")

endmodule

bind generational_handle_allocator_top gha_checker u_gha_checker (.*);

### dv/tb.sv
// Self-checking testbench for the generational handle allocator: a stream driver,
// a result monitor and an in-line prediction of the slot tables and the free list.
// Depends on gha_pkg and generational_handle_allocator_top.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic                      opc;
    logic [gha_pkg::ID_W-1:0]  id;
    logic [gha_pkg::VER_W-1:0] ver;
  } request_t;

  typedef struct {
    logic                      opc;
    logic [1:0]                status;
    logic [gha_pkg::ID_W-1:0]  id;
    logic [gha_pkg::VER_W-1:0] ver;
  } handle_result_t;

  typedef struct {
    logic [gha_pkg::ID_W-1:0]  id;
    logic [gha_pkg::VER_W-1:0] ver;
  } handle_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = gha_pkg::OP_ALLOC;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  generational_handle_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Predicted allocator state.
  logic [gha_pkg::ID_W-1:0]  link_mem [gha_pkg::SLOT_COUNT];
  logic [gha_pkg::VER_W-1:0] gen_mem  [gha_pkg::SLOT_COUNT];
  bit                        alive_mem[gha_pkg::SLOT_COUNT];
  logic [gha_pkg::ID_W-1:0]  head_slot = '0;
  bit                        head_valid = 1'b0;
  int                        fill_count = 0;

  request_t       request_q[$];
  handle_result_t handle_results_q[$];
  handle_t        live_pool[$];
  handle_t        retired_pool[$];

  int mismatch_count = 0;
  int results_seen = 0;
  int allocs_ok = 0;
  int frees_ok = 0;
  int stale_seen = 0;
  int full_seen = 0;
  int issued = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the single result of an accepted request and updates the tables.
  function automatic void predict_handle_op(input request_t req);
    handle_result_t r;
    logic [gha_pkg::ID_W-1:0] slot;
    logic [gha_pkg::ID_W-1:0] nxt;
    r.opc = req.opc;
    r.status = gha_pkg::ST_OK;
    r.id = '0;
    r.ver = '0;
    if (req.opc == gha_pkg::OP_ALLOC) begin
      if (head_valid) begin
        slot = head_slot;
        nxt = link_mem[slot];
        alive_mem[slot] = 1'b1;
        // A self link or a link to a live or unused slot ends the list.
        if (nxt != slot && !alive_mem[nxt] && nxt < fill_count) begin
          head_slot = nxt;
        end else begin
          head_valid = 1'b0;
        end
        r.id = slot;
        r.ver = gen_mem[slot];
      end else if (fill_count < gha_pkg::SLOT_COUNT) begin
        slot = fill_count[gha_pkg::ID_W-1:0];
        gen_mem[slot] = '0;
        alive_mem[slot] = 1'b1;
        fill_count++;
        r.id = slot;
      end else begin
        r.status = gha_pkg::ST_FULL;
      end
    end else begin
      if (req.id >= fill_count || !alive_mem[req.id] || gen_mem[req.id] != req.ver) begin
        r.status = gha_pkg::ST_STALE;
      end else begin
        link_mem[req.id] = head_valid ? head_slot : req.id;
        head_slot = req.id;
        head_valid = 1'b1;
        alive_mem[req.id] = 1'b0;
        gen_mem[req.id] = gen_mem[req.id] + 1'b1;
      end
    end
    handle_results_q.push_back(r);
  endfunction

  // Driver: bursts of random length separated by random gaps.
  request_t cur_req = '{gha_pkg::OP_ALLOC, '0, '0};
  bit       have_req = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      have_req = 1'b0;
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_handle_op(cur_req);
        have_req = 1'b0;
      end
      if (!have_req) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          have_req = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
          end
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_tvalid <= have_req;
      in_tuser <= cur_req.opc;
      in_tdata <= {6'b0, cur_req.ver, cur_req.id};
    end
  end

  // Monitor: checks each result transaction and drives a stall pattern of its own.
  int rx_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit rdy;

  task automatic check_result();
    handle_result_t exp;
    if (handle_results_q.size() == 0) begin
      $display("%0t: unexpected result, status %0d id %0d version %0d", $time,
               out_tuser, out_tdata[9:0], out_tdata[25:10]);
      mismatch_count++;
    end else begin
      exp = handle_results_q.pop_front();
      if (out_tuser !== exp.status) begin
        $display("%0t: status expected %0d, actual %0d", $time, exp.status, out_tuser);
        mismatch_count++;
      end
      if (out_tdata[9:0] !== exp.id) begin
        $display("%0t: id expected %0d, actual %0d", $time, exp.id, out_tdata[9:0]);
        mismatch_count++;
      end
      if (out_tdata[25:10] !== exp.ver) begin
        $display("%0t: version expected %0d, actual %0d", $time, exp.ver,
                 out_tdata[25:10]);
        mismatch_count++;
      end
      unique case (exp.status)
        gha_pkg::ST_OK: begin
          if (exp.opc == gha_pkg::OP_ALLOC) begin
            allocs_ok++;
            live_pool.push_back('{exp.id, exp.ver});
          end else begin
            frees_ok++;
          end
        end
        gha_pkg::ST_STALE: stale_seen++;
        default: full_seen++;
      endcase
    end
    results_seen++;
    // One long hold-off while the sender keeps offering, so the input backs up.
    if (results_seen == 300) begin
      hold_left = 250;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_result();
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        unique case (rx_mode)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_tready <= rdy;
    end
  end

  // Stimulus is queued lazily so that frees can name handles already returned.
  task automatic issue(input logic opc, input logic [gha_pkg::ID_W-1:0] id,
                       input logic [gha_pkg::VER_W-1:0] ver);
    while (request_q.size() >= 4) @(negedge clk);
    request_q.push_back('{opc, id, ver});
    issued++;
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_tvalid || handle_results_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic issue_random(input int alloc_weight);
    int pick;
    int idx;
    handle_t h;
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 99) < alloc_weight) begin
      issue(gha_pkg::OP_ALLOC, gha_pkg::ID_W'($urandom), gha_pkg::VER_W'($urandom));
    end else if (pick <= 6 && live_pool.size() > 0) begin
      idx = $urandom_range(0, live_pool.size() - 1);
      h = live_pool[idx];
      live_pool.delete(idx);
      retired_pool.push_back(h);
      if (retired_pool.size() > 64) begin
        void'(retired_pool.pop_front());
      end
      issue(gha_pkg::OP_FREE, h.id, h.ver);
    end else if (pick <= 8 && retired_pool.size() > 0) begin
      // Old handle, either as it was or with its version plus one, as its slot carried after that free.
      h = retired_pool[$urandom_range(0, retired_pool.size() - 1)];
      issue(gha_pkg::OP_FREE, h.id, gha_pkg::VER_W'(h.ver + $urandom_range(0, 1)));
    end else if (pick <= 8) begin
      issue(gha_pkg::OP_ALLOC, gha_pkg::ID_W'($urandom), gha_pkg::VER_W'($urandom));
    end else begin
      issue(gha_pkg::OP_FREE, gha_pkg::ID_W'($urandom_range(0, gha_pkg::SLOT_COUNT - 1)),
            gha_pkg::VER_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom));
    end
  endtask

  initial begin
    int phase_items;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: free before any allocation, double free, wrong and all-ones
    // versions, an id never handed out, and pops down to the end of the list.
    issue(gha_pkg::OP_FREE, 10'd0, 16'd0);
    issue(gha_pkg::OP_ALLOC, 10'd0, 16'd0);
    issue(gha_pkg::OP_ALLOC, 10'd0, 16'd0);
    issue(gha_pkg::OP_ALLOC, 10'd0, 16'd0);
    issue(gha_pkg::OP_FREE, 10'd1, 16'd0);
    issue(gha_pkg::OP_FREE, 10'd1, 16'd0);
    issue(gha_pkg::OP_FREE, 10'd1, 16'd1);
    issue(gha_pkg::OP_FREE, 10'd2, 16'hFFFF);
    issue(gha_pkg::OP_FREE, 10'h3FF, 16'hFFFF);
    issue(gha_pkg::OP_FREE, 10'd0, 16'd0);
    issue(gha_pkg::OP_ALLOC, 10'd0, 16'd0);
    issue(gha_pkg::OP_ALLOC, 10'd0, 16'd0);
    issue(gha_pkg::OP_ALLOC, 10'd0, 16'd0);
    issue(gha_pkg::OP_FREE, 10'd3, 16'd0);
    issue(gha_pkg::OP_FREE, 10'd2, 16'd0);
    issue(gha_pkg::OP_ALLOC, 10'd0, 16'd0);
    issue(gha_pkg::OP_ALLOC, 10'd0, 16'd0);
    issue(gha_pkg::OP_FREE, 10'd3, 16'd1);
    issue(gha_pkg::OP_ALLOC, 10'd0, 16'd0);
    issue(gha_pkg::OP_ALLOC, 10'h3FF, 16'hFFFF);
    wait_idle();
    live_pool.delete();
    retired_pool.delete();

    // Mixed traffic on a partly used table.
    repeat (200) issue_random(40);

    // Allocation-heavy traffic until the table has reported full ten times, capped at 1200 requests.
    phase_items = 0;
    while (full_seen < 10 && phase_items < 1200) begin
      issue_random(95);
      phase_items++;
    end
    wait_idle();

    // Churn on a full table: frees feed the list, allocations drain it.
    phase_items = (issued < 1270) ? 1420 - issued : 150;
    repeat (phase_items) issue_random(35);

    wait_idle();
    repeat (16) @(negedge clk);
    $display("Run covered %0d requests: %0d handles allocated, %0d freed,", issued,
             allocs_ok, frees_ok);
    $display("%0d stale frees refused and %0d full responses.", stale_seen, full_seen);
    if (mismatch_count == 0 && handle_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", handle_results_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
